// ----- rtl/sdf_pkg.sv -----
// Shared constants and types for the scanline dedup block.
// No dependencies; used by every module under rtl/.
package sdf_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_UNIQUE = 256;
    localparam int POS_W      = $clog2(MAX_WIDTH);
    localparam int SLOT_W     = $clog2(MAX_UNIQUE);
    localparam int WIDTH_W    = 9;
    localparam int ROW_W      = 12;
    localparam int CNT_W      = SLOT_W + 1;

    localparam logic [31:0]        FNV_BASIS     = 32'h811c9dc5;
    localparam logic [31:0]        FNV_PRIME     = 32'h01000193;
    localparam logic [WIDTH_W-1:0] WIDTH_DEFAULT = 9'd256;
    localparam logic [WIDTH_W-1:0] WIDTH_MAX     = 9'd256;

    // One finished row handed from the front to the back.
    typedef struct packed {
        logic               bank;
        logic [31:0]        hash;
        logic [ROW_W-1:0]   row;
        logic [WIDTH_W-1:0] width;
        logic               clear;
    } job_t;

    // Row buffer write from the front.
    typedef struct packed {
        logic             en;
        logic             bank;
        logic [POS_W-1:0] pos;
        logic [7:0]       data;
    } buf_wr_t;

endpackage

// ----- rtl/sdf_front.sv -----
// Front part: accepts pixel words, hashes each row and issues row jobs.
// Depends on sdf_pkg.
module sdf_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // pixel[7:0]
    input  logic                        s_tuser,   // first_of_set
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [sdf_pkg::WIDTH_W-1:0] cfg_data,
    input  logic                        done,
    output logic                        push,
    output sdf_pkg::job_t               job,
    output sdf_pkg::buf_wr_t            buf_wr
);

    logic [sdf_pkg::WIDTH_W-1:0] row_width_reg;
    logic [31:0]                 hash_reg, hash_next;
    logic [sdf_pkg::WIDTH_W-1:0] pos_reg, pos_next;
    logic [sdf_pkg::ROW_W-1:0]   row_reg, row_next;
    logic                        bank_reg, bank_next;
    logic                        clear_reg, clear_next;
    logic [1:0]                  outst_reg, outst_next;

    logic                        accept;
    logic [31:0]                 h0, hn;
    logic [sdf_pkg::WIDTH_W-1:0] p0, w;
    logic [sdf_pkg::ROW_W-1:0]   r0;
    logic                        clr, row_end;

    assign cfg_ready = 1'b1;
    assign s_tready  = (outst_reg != 2'd2);
    assign accept    = s_tvalid && s_tready;

    always_comb
    begin
        h0  = s_tuser ? sdf_pkg::FNV_BASIS : hash_reg;
        p0  = s_tuser ? '0 : pos_reg;
        r0  = s_tuser ? '0 : row_reg;
        clr = s_tuser | clear_reg;
        hn  = 32'(h0 * sdf_pkg::FNV_PRIME) ^ {24'd0, s_tdata};
        if (row_width_reg == '0)
            w = sdf_pkg::WIDTH_W'(1);
        else if (row_width_reg > sdf_pkg::WIDTH_MAX)
            w = sdf_pkg::WIDTH_MAX;
        else
            w = row_width_reg;
        row_end = ((p0 + 1'b1) >= w);
    end

    always_comb
    begin
        hash_next  = hash_reg;
        pos_next   = pos_reg;
        row_next   = row_reg;
        bank_next  = bank_reg;
        clear_next = clear_reg;
        push       = 1'b0;
        if (accept)
        begin
            if (row_end)
            begin
                push       = 1'b1;
                hash_next  = sdf_pkg::FNV_BASIS;
                pos_next   = '0;
                row_next   = r0 + 1'b1;
                bank_next  = ~bank_reg;
                clear_next = 1'b0;
            end
            else
            begin
                hash_next  = hn;
                pos_next   = p0 + 1'b1;
                row_next   = r0;
                clear_next = clr;
            end
        end
        outst_next = outst_reg + {1'b0, push} - {1'b0, done};
    end

    assign job.bank  = bank_reg;
    assign job.hash  = hn;
    assign job.row   = r0;
    assign job.width = w;
    assign job.clear = clr;

    assign buf_wr.en   = accept;
    assign buf_wr.bank = bank_reg;
    assign buf_wr.pos  = p0[sdf_pkg::POS_W-1:0];
    assign buf_wr.data = s_tdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= sdf_pkg::WIDTH_DEFAULT;
            hash_reg      <= sdf_pkg::FNV_BASIS;
            pos_reg       <= '0;
            row_reg       <= '0;
            bank_reg      <= 1'b0;
            clear_reg     <= 1'b0;
            outst_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                row_width_reg <= cfg_data;
            hash_reg  <= hash_next;
            pos_reg   <= pos_next;
            row_reg   <= row_next;
            bank_reg  <= bank_next;
            clear_reg <= clear_next;
            outst_reg <= outst_next;
        end
    end

endmodule

// ----- rtl/sdf_queue.sv -----
// Two-entry job queue between the front and the back.
// Depends on sdf_pkg.
module sdf_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sdf_pkg::job_t din,
    input  logic          pop,
    output sdf_pkg::job_t dout,
    output logic          empty
);

    sdf_pkg::job_t slot_reg [2];
    logic          wp_reg, rp_reg;
    logic [1:0]    fill_reg;

    assign empty = (fill_reg == 2'd0);
    assign dout  = slot_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wp_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ----- rtl/sdf_back.sv -----
// Back part: searches the unique store for each row job, stores new rows
// and holds the result word. Depends on sdf_pkg.
module sdf_back (
    input  logic             clk,
    input  logic             rst_n,
    input  sdf_pkg::buf_wr_t buf_wr,
    input  logic             q_empty,
    input  sdf_pkg::job_t    q_job,
    output logic             pop,
    output logic             done,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [63:0]      m_tdata
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_HRD  = 8'b0000_0010,
        ST_HCHK = 8'b0000_0100,
        ST_BRD  = 8'b0000_1000,
        ST_BCHK = 8'b0001_0000,
        ST_CRD  = 8'b0010_0000,
        ST_CWR  = 8'b0100_0000,
        ST_RES  = 8'b1000_0000
    } state_t;

    localparam int BUF_AW = sdf_pkg::POS_W + 1;
    localparam int UB_AW  = sdf_pkg::SLOT_W + sdf_pkg::POS_W;

    logic [7:0]                rowbuf [2**BUF_AW];
    logic [7:0]                ubytes [2**UB_AW];
    logic [31:0]               uhash  [sdf_pkg::MAX_UNIQUE];
    logic [sdf_pkg::ROW_W-1:0] urow   [sdf_pkg::MAX_UNIQUE];

    state_t                      state_reg, state_next;
    sdf_pkg::job_t               job_reg, job_next;
    logic [sdf_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [sdf_pkg::CNT_W-1:0]   k_reg, k_next;
    logic [sdf_pkg::WIDTH_W-1:0] j_reg, j_next;
    logic                        dup_reg, dup_next;
    logic                        full_reg, full_next;
    logic [sdf_pkg::ROW_W-1:0]   orig_reg, orig_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [63:0]                 m_tdata_reg;
    logic [31:0]                 hq_reg;
    logic [sdf_pkg::ROW_W-1:0]   rq_reg;
    logic [7:0]                  bq_reg, cq_reg;
    logic                        out_free, last_byte;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign last_byte = ((j_reg + 1'b1) >= job_reg.width);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb
    begin
        state_next    = state_reg;
        job_next      = job_reg;
        cnt_next      = cnt_reg;
        k_next        = k_reg;
        j_next        = j_reg;
        dup_next      = dup_reg;
        full_next     = full_reg;
        orig_next     = orig_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        pop           = 1'b0;
        done          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    job_next   = q_job;
                    k_next     = '0;
                    state_next = ST_HRD;
                    if (q_job.clear)
                        cnt_next = '0;
                end
            end
            ST_HRD:
            begin
                if (k_reg < cnt_reg)
                    state_next = ST_HCHK;
                else
                begin
                    dup_next  = 1'b0;
                    orig_next = job_reg.row;
                    j_next    = '0;
                    if (cnt_reg < sdf_pkg::CNT_W'(sdf_pkg::MAX_UNIQUE))
                    begin
                        full_next  = 1'b0;
                        state_next = ST_CRD;
                    end
                    else
                    begin
                        full_next  = 1'b1;
                        state_next = ST_RES;
                    end
                end
            end
            ST_HCHK:
            begin
                if (hq_reg == job_reg.hash)
                begin
                    j_next     = '0;
                    state_next = ST_BRD;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_HRD;
                end
            end
            ST_BRD:
                state_next = ST_BCHK;
            ST_BCHK:
            begin
                if (bq_reg != cq_reg)
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_HRD;
                end
                else if (last_byte)
                begin
                    dup_next   = 1'b1;
                    full_next  = 1'b0;
                    orig_next  = rq_reg;
                    state_next = ST_RES;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_BRD;
                end
            end
            ST_CRD:
                state_next = ST_CWR;
            ST_CWR:
            begin
                if (last_byte)
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_RES;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_CRD;
                end
            end
            ST_RES:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    done          = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Memories: registered reads, no reset.
    always_ff @(posedge clk)
    begin
        if (buf_wr.en)
            rowbuf[{buf_wr.bank, buf_wr.pos}] <= buf_wr.data;
        if (state_reg == ST_HRD)
        begin
            hq_reg <= uhash[k_reg[sdf_pkg::SLOT_W-1:0]];
            rq_reg <= urow[k_reg[sdf_pkg::SLOT_W-1:0]];
        end
        if (state_reg == ST_BRD)
            bq_reg <= ubytes[{k_reg[sdf_pkg::SLOT_W-1:0], j_reg[sdf_pkg::POS_W-1:0]}];
        if (state_reg == ST_BRD || state_reg == ST_CRD)
            cq_reg <= rowbuf[{job_reg.bank, j_reg[sdf_pkg::POS_W-1:0]}];
        if (state_reg == ST_CWR)
        begin
            ubytes[{cnt_reg[sdf_pkg::SLOT_W-1:0], j_reg[sdf_pkg::POS_W-1:0]}] <= cq_reg;
            if (j_reg == '0)
            begin
                uhash[cnt_reg[sdf_pkg::SLOT_W-1:0]] <= job_reg.hash;
                urow[cnt_reg[sdf_pkg::SLOT_W-1:0]]  <= job_reg.row;
            end
        end
        if (state_reg == ST_RES && out_free)
            m_tdata_reg <= {6'd0, full_reg, job_reg.hash, orig_reg, dup_reg, job_reg.row};
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        k_reg    <= k_next;
        j_reg    <= j_next;
        dup_reg  <= dup_next;
        full_reg <= full_next;
        orig_reg <= orig_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= sdf_pkg::CNT_W'(sdf_pkg::MAX_UNIQUE))
        else $error("unique count beyond store depth");

    a_byte_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BCHK || state_reg == ST_CWR) |-> (j_reg < job_reg.width))
        else $error("byte index past row width");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> m_tvalid_reg)
        else $error("finished job produced no result word");

endmodule

// ----- rtl/scanline_dedup_fnv1.sv -----
// Scanline dedup by 32-bit FNV-1 hash: one pixel word per cycle while a row
// buffer bank is free; row search runs behind a two-job queue.
// For each row job the back reads and checks the hash of each stored row, reads
// and compares each byte on a hash hit, and copies a new unique row byte by
// byte, a read then a write, if the store has room.
// Reset: row count, store count and queue clear at once; stores need no pass.
module scanline_dedup_fnv1 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // pixel[7:0]
    input  logic        s_tuser,   // first_of_set
    output logic        m_tvalid,
    input  logic        m_tready,
    // row_index[11:0], is_duplicate[12], original_row[24:13],
    // row_hash[56:25], store_full[57], zero[63:58]
    output logic [63:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data   // row_width
);

    sdf_pkg::job_t    push_job, q_job;
    sdf_pkg::buf_wr_t buf_wr;
    logic             push, pop, q_empty, done;

    // Hash pixels and write the row buffer bank in use.
    sdf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .done      (done),
        .push      (push),
        .job       (push_job),
        .buf_wr    (buf_wr)
    );

    // Hold finished rows until the back is free.
    sdf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_job),
        .pop   (pop),
        .dout  (q_job),
        .empty (q_empty)
    );

    // Search, store and report each row.
    sdf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .buf_wr   (buf_wr),
        .q_empty  (q_empty),
        .q_job    (q_job),
        .pop      (pop),
        .done     (done),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
